FILE: sv/lwbc_pkg.sv
// Shared types and sizes for the LRU write-back block cache.
// No dependencies; imported by every cache module.
`timescale 1ns / 1ps

package lwbc_pkg;

  // Geometry
  localparam int ENTRIES   = 16;
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 64;
  localparam int CAP_W     = 5;
  localparam int AGE_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CMP_W     = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int CAP_RESET = 16;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [AGE_W-1:0]   age_t;
  typedef logic [ENTRIES-1:0] vec_t;

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // One registered access word
  typedef struct packed {
    op_t   op;
    key_t  key;
    data_t wdata;
    data_t fdata;
  } req_t;

  // Lookup decisions handed to the entry store
  typedef struct packed {
    logic found;
    logic evict;
    vec_t hit_oh;
    vec_t victim_oh;
    vec_t fill_oh;
    vec_t sel_oh;
    age_t old_age;
  } lookup_t;

endpackage

FILE: sv/lru_writeback_block_cache.sv
// Fully associative LRU block cache, write-back of every evicted entry.
// Timing: start is captured in the request register; done and the result word
// are then registered from the request register.
// Throughput: one word per cycle; the whole lookup and update is combinational
// between the request register and the result register; busy stays low.
// Reset clears all entry valid bits and ranks and sets capacity to 16.
`timescale 1ns / 1ps

module lru_writeback_block_cache (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation,
  input  lwbc_pkg::key_t             block_key,
  input  lwbc_pkg::data_t            write_data,
  input  lwbc_pkg::data_t            fill_data,
  input  logic                       capacity_we,
  input  logic [lwbc_pkg::CAP_W-1:0] capacity_data,
  output logic                       done,
  output logic                       hit,
  output lwbc_pkg::data_t            read_data,
  output logic                       writeback_valid,
  output lwbc_pkg::key_t             writeback_key,
  output lwbc_pkg::data_t            writeback_data
);
  import lwbc_pkg::*;

  logic [CAP_W-1:0]    capacity;
  logic                req_valid;
  req_t                req;
  lookup_t             lk;
  vec_t                valid;
  key_t  [ENTRIES-1:0] keys;
  age_t  [ENTRIES-1:0] ages;
  key_t                sel_key;
  data_t               sel_data;
  data_t               read_data_next;

  // Lookup and update are combinational between the registers, so no word is ever refused
  assign busy = 1'b0;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(CAP_RESET);
    end else if (capacity_we) begin
      capacity <= capacity_data;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.op    <= op_t'(operation);
      req.key   <= block_key;
      req.wdata <= write_data;
      req.fdata <= fill_data;
    end
  end

  lwbc_lookup u_lookup (
    .key      (req.key),
    .capacity (capacity),
    .valid    (valid),
    .keys     (keys),
    .ages     (ages),
    .lk       (lk)
  );

  lwbc_entries u_entries (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .lk        (lk),
    .valid     (valid),
    .keys      (keys),
    .ages      (ages),
    .sel_key   (sel_key),
    .sel_data  (sel_data)
  );

  // Get returns stored data on a hit, fill data on a miss; put returns zero
  always_comb begin
    if (req.op == OP_PUT) begin
      read_data_next = '0;
    end else if (lk.found) begin
      read_data_next = sel_data;
    end else begin
      read_data_next = req.fdata;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (req_valid) begin
      hit             <= lk.found;
      read_data       <= read_data_next;
      writeback_valid <= lk.evict;
      writeback_key   <= lk.evict ? sel_key : '0;
      writeback_data  <= lk.evict ? sel_data : '0;
    end
  end

endmodule

FILE: sv/lwbc_lookup.sv
// Tag compare, occupancy count, victim and free-slot selection.
// Purely combinational; depends on lwbc_pkg.
`timescale 1ns / 1ps

module lwbc_lookup (
  input  lwbc_pkg::key_t                         key,
  input  logic [lwbc_pkg::CAP_W-1:0]             capacity,
  input  lwbc_pkg::vec_t                         valid,
  input  lwbc_pkg::key_t [lwbc_pkg::ENTRIES-1:0] keys,
  input  lwbc_pkg::age_t [lwbc_pkg::ENTRIES-1:0] ages,
  output lwbc_pkg::lookup_t                      lk
);
  import lwbc_pkg::*;

  vec_t               match;
  vec_t               oldest;
  vec_t               kept;
  vec_t               free_vec;
  logic [CNT_W-1:0]   count;
  logic [CMP_W-1:0]   eff_cap;
  age_t               top_age;
  age_t               old_age;

  // Parallel tag compare and occupancy count
  always_comb begin
    count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == key);
      count    = count + CNT_W'(valid[i]);
    end
  end

  // Capacity clamped to 1..ENTRIES
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  // Valid ages are a permutation of 0..count-1, so the oldest holds count-1
  assign top_age = AGE_W'(count - CNT_W'(1));

  // Keys are unique among valid entries, so at most one match bit is set
  always_comb begin
    old_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      oldest[i] = valid[i] && (ages[i] == top_age);
      if (match[i]) begin
        old_age = old_age | ages[i];
      end
    end
  end

  // Lowest-index picks
  always_comb begin
    lk.found     = |match;
    lk.hit_oh    = match & (~match + ENTRIES'(1));
    lk.victim_oh = oldest & (~oldest + ENTRIES'(1));
    lk.evict     = !lk.found && (CMP_W'(count) >= eff_cap);
    kept         = valid & ~(lk.evict ? lk.victim_oh : '0);
    free_vec     = ~kept;
    lk.fill_oh   = lk.found ? '0 : (free_vec & (~free_vec + ENTRIES'(1)));
    lk.sel_oh    = lk.found ? lk.hit_oh : lk.victim_oh;
    lk.old_age   = old_age;
  end

endmodule

FILE: sv/lwbc_entries.sv
// Entry store: valid bits, keys, data and recency ranks with their update.
// Depends on lwbc_pkg; driven by decisions from lwbc_lookup.
`timescale 1ns / 1ps

module lwbc_entries (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  input  lwbc_pkg::req_t                         req,
  input  lwbc_pkg::lookup_t                      lk,
  output lwbc_pkg::vec_t                         valid,
  output lwbc_pkg::key_t [lwbc_pkg::ENTRIES-1:0] keys,
  output lwbc_pkg::age_t [lwbc_pkg::ENTRIES-1:0] ages,
  output lwbc_pkg::key_t                         sel_key,
  output lwbc_pkg::data_t                        sel_data
);
  import lwbc_pkg::*;

  data_t [ENTRIES-1:0] data;
  vec_t                valid_next;
  key_t  [ENTRIES-1:0] keys_next;
  data_t [ENTRIES-1:0] data_next;
  age_t  [ENTRIES-1:0] ages_next;
  data_t               new_data;
  logic                kept;

  assign new_data = (req.op == OP_GET) ? req.fdata : req.wdata;

  // Next state for one access
  always_comb begin
    valid_next = valid;
    keys_next  = keys;
    data_next  = data;
    ages_next  = ages;
    kept       = 1'b0;
    if (req_valid) begin
      if (lk.found) begin
        // hit: entries younger than the touched one age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (lk.hit_oh[i]) begin
            ages_next[i] = '0;
            if (req.op == OP_PUT) begin
              data_next[i] = req.wdata;
            end
          end else if (valid[i] && (ages[i] < lk.old_age)) begin
            ages_next[i] = AGE_W'(ages[i] + AGE_W'(1));
          end
        end
      end else begin
        // miss: drop victim if any, age survivors, install at free slot
        for (int i = 0; i < ENTRIES; i++) begin
          kept          = valid[i] && !(lk.evict && lk.victim_oh[i]);
          valid_next[i] = kept || lk.fill_oh[i];
          if (lk.fill_oh[i]) begin
            ages_next[i] = '0;
            keys_next[i] = req.key;
            data_next[i] = new_data;
          end else if (kept) begin
            ages_next[i] = AGE_W'(ages[i] + AGE_W'(1));
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ages  <= '0;
    end else begin
      valid <= valid_next;
      ages  <= ages_next;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    keys <= keys_next;
    data <= data_next;
  end

  // One-hot read of the hit or victim entry
  always_comb begin
    sel_key  = '0;
    sel_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (lk.sel_oh[i]) begin
        sel_key  = sel_key | keys[i];
        sel_data = sel_data | data[i];
      end
    end
  end

endmodule

FILE: bench/lru_writeback_block_cache_tb.sv
// Self-checking bench for the LRU write-back block cache: directed table, then random phases.
// Depends on lwbc_pkg and lru_writeback_block_cache; a built-in predictor tracks the entries.
`timescale 1ns / 1ps

module lru_writeback_block_cache_tb;
  import lwbc_pkg::*;

  localparam int          NUM_PHASES       = 10;
  localparam int          WORDS_PER_PHASE  = 170;
  localparam int          QUIET_PHASE      = 5;
  localparam int          RANDOM_CAP_PHASE = 8;
  localparam int          POOL_MAX         = 24;
  localparam int          DRAIN_LIMIT      = 1000;
  localparam int          MAX_REPORTS      = 60;
  localparam longint      LIMIT_NS         = 5_000_000;
  localparam data_t       ONES64           = '1;
  localparam key_t        ONES32           = '1;

  typedef enum logic { ROW_ACCESS = 1'b0, ROW_CAP = 1'b1 } row_kind_t;

  // Outcome of one access word
  typedef struct packed {
    logic  hit;
    data_t rdata;
    logic  wb_valid;
    key_t  wb_key;
    data_t wb_data;
  } cache_result_t;

  // One line of the directed table
  typedef struct packed {
    row_kind_t          kind;
    logic [CAP_W-1:0]   cap;
    op_t                op;
    key_t               key;
    data_t              wdata;
    data_t              fdata;
    logic               typed;
    cache_result_t      want;
  } dir_row_t;

  localparam cache_result_t NO_WANT = '0;
  localparam int NUM_DIR_ROWS = 24;

  localparam logic [CAP_W-1:0] PHASE_CAPS [NUM_PHASES] =
    '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd8, 5'd17, 5'd0, 5'd3};

  // Directed words: typed results only where they follow directly from the sequence
  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0000, 64'h0, ONES64,
     1'b1, {1'b0, ONES64, 1'b0, 32'h0, 64'h0}},
    {ROW_ACCESS, 5'd0, OP_PUT, ONES32, 64'h0, 64'h1234,
     1'b1, {1'b0, 64'h0, 1'b0, 32'h0, 64'h0}},
    {ROW_ACCESS, 5'd0, OP_GET, ONES32, ONES64, ONES64,
     1'b1, {1'b1, 64'h0, 1'b0, 32'h0, 64'h0}},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0000, 64'h0, 64'h0,
     1'b1, {1'b1, ONES64, 1'b0, 32'h0, 64'h0}},
    {ROW_ACCESS, 5'd0, OP_PUT, 32'h0000_0000, 64'h5555_5555_5555_5555, 64'h0,
     1'b1, {1'b1, 64'h0, 1'b0, 32'h0, 64'h0}},
    // shrink below occupancy: hits must not evict
    {ROW_CAP, 5'd1, OP_GET, 32'h0, 64'h0, 64'h0, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0000, 64'h0, 64'h0,
     1'b1, {1'b1, 64'h5555_5555_5555_5555, 1'b0, 32'h0, 64'h0}},
    // put miss at capacity evicts the oldest entry
    {ROW_ACCESS, 5'd0, OP_PUT, 32'h1234_5678, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0,
     1'b1, {1'b0, 64'h0, 1'b1, ONES32, 64'h0}},
    {ROW_ACCESS, 5'd0, OP_GET, 32'hDEAD_BEEF, 64'h0, 64'h0123_4567_89AB_CDEF,
     1'b0, NO_WANT},
    // capacity zero behaves as one
    {ROW_CAP, 5'd0, OP_GET, 32'h0, 64'h0, 64'h0, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0BAD_F00D, 64'h0, 64'h8000_0000_0000_0001,
     1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0BAD_F00D, 64'h0, 64'h0, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_PUT, 32'h0BAD_F00D, ONES64, 64'h0, 1'b0, NO_WANT},
    // capacity above the entry count behaves as full size
    {ROW_CAP, 5'd31, OP_GET, 32'h0, 64'h0, 64'h0, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0001, 64'h0, 64'h1, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0002, 64'h0, 64'h2, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0004, 64'h0, 64'h4, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_PUT, 32'h8000_0000, 64'h8000_0000_0000_0000, 64'h0,
     1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0001, 64'h0, 64'h0, 1'b0, NO_WANT},
    {ROW_CAP, 5'd2, OP_GET, 32'h0, 64'h0, 64'h0, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_PUT, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0,
     1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h0000_0002, 64'h0, ONES64, 1'b0, NO_WANT},
    {ROW_ACCESS, 5'd0, OP_GET, 32'h8000_0000, 64'h0, 64'h0, 1'b0, NO_WANT},
    {ROW_CAP, 5'd16, OP_GET, 32'h0, 64'h0, 64'h0, 1'b0, NO_WANT}
  };

  // DUT connections
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             operation = 1'b0;
  key_t             block_key = '0;
  data_t            write_data = '0;
  data_t            fill_data = '0;
  logic             capacity_we = 1'b0;
  logic [CAP_W-1:0] capacity_data = '0;
  logic             done;
  logic             hit;
  data_t            read_data;
  logic             writeback_valid;
  key_t             writeback_key;
  data_t            writeback_data;

  // Predictor state: entry contents, recency ranks and capacity
  bit               shadow_valid [ENTRIES];
  key_t             shadow_key [ENTRIES];
  data_t            shadow_data [ENTRIES];
  int unsigned      shadow_rank [ENTRIES];
  logic [CAP_W-1:0] shadow_capacity = 5'(CAP_RESET);

  cache_result_t    pending_results [$];
  bit               idle_on = 1'b1;
  int               error_count = 0;
  int               access_count = 0;
  int               hit_count = 0;
  int               writeback_count = 0;
  int               cap_writes = 0;

  lru_writeback_block_cache dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .block_key       (block_key),
    .write_data      (write_data),
    .fill_data       (fill_data),
    .capacity_we     (capacity_we),
    .capacity_data   (capacity_data),
    .done            (done),
    .hit             (hit),
    .read_data       (read_data),
    .writeback_valid (writeback_valid),
    .writeback_key   (writeback_key),
    .writeback_data  (writeback_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(LIMIT_NS);
    $display("lru_writeback_block_cache_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_REPORTS)
      $display("MISMATCH @%0t %s: got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Predict one access word and update the shadow entries
  function automatic cache_result_t cache_lookup_update(input op_t op, input key_t key,
                                                        input data_t wdata,
                                                        input data_t fdata);
    cache_result_t res;
    int            count;
    int            slot;
    int            victim;
    int            cap_eff;
    bit            found;
    int unsigned   old_rank;
    res = '0;
    count = 0;
    slot = -1;
    victim = -1;
    found = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i]) begin
        count++;
        if (!found && shadow_key[i] == key) begin
          found = 1'b1;
          slot = i;
        end
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (op == OP_GET) res.rdata = shadow_data[slot];
      else shadow_data[slot] = wdata;
      old_rank = shadow_rank[slot];
      for (int i = 0; i < ENTRIES; i++)
        if (shadow_valid[i] && i != slot && shadow_rank[i] < old_rank)
          shadow_rank[i]++;
      shadow_rank[slot] = 0;
    end else begin
      cap_eff = (shadow_capacity == 0) ? 1 :
                (shadow_capacity > ENTRIES) ? ENTRIES : int'(shadow_capacity);
      // full: drop the oldest entry, always written back
      if (count >= cap_eff) begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
            victim = i;
        if (victim >= 0) begin
          res.wb_valid = 1'b1;
          res.wb_key = shadow_key[victim];
          res.wb_data = shadow_data[victim];
          shadow_valid[victim] = 1'b0;
        end
      end
      // install in the lowest free slot as most recent
      for (int i = 0; i < ENTRIES; i++)
        if (!shadow_valid[i] && slot < 0) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_valid[slot] = 1'b1;
        shadow_key[slot] = key;
        shadow_data[slot] = (op == OP_GET) ? fdata : wdata;
        shadow_rank[slot] = 0;
      end
      if (op == OP_GET) res.rdata = fdata;
    end
    return res;
  endfunction

  // Drive one access word; random idle cycles before it when enabled
  task automatic send_word(input op_t op, input key_t key, input data_t wdata,
                           input data_t fdata, input logic typed,
                           input cache_result_t want);
    cache_result_t predicted;
    while (idle_on && $urandom_range(99) < 34) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    block_key <= key;
    write_data <= wdata;
    fill_data <= fdata;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = cache_lookup_update(op, key, wdata, fdata);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Capacity is only written once the cache has gone quiet
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    capacity_we <= 1'b1;
    capacity_data <= value;
    @(posedge clk);
    shadow_capacity = value;
    cap_writes++;
    @(negedge clk);
    capacity_we <= 1'b0;
  endtask

  // Result checker: every strobed word against the oldest prediction
  always @(posedge clk) begin : result_check
    cache_result_t want;
    if (!rst && done) begin
      access_count++;
      if (hit === 1'b1) hit_count++;
      if (writeback_valid === 1'b1) writeback_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no pending access", 64'(hit), 64'h0);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 64'(hit), 64'(want.hit));
        if (read_data !== want.rdata) report_mismatch("read_data", read_data, want.rdata);
        if (writeback_valid !== want.wb_valid)
          report_mismatch("writeback_valid", 64'(writeback_valid), 64'(want.wb_valid));
        if (writeback_key !== want.wb_key)
          report_mismatch("writeback_key", 64'(writeback_key), 64'(want.wb_key));
        if (writeback_data !== want.wb_data)
          report_mismatch("writeback_data", writeback_data, want.wb_data);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    key_t             key_pool [POOL_MAX];
    int               pool_n;
    int               pick;
    int               drain;
    key_t             key;
    logic [CAP_W-1:0] cap;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_data[i] = '0;
      shadow_rank[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < NUM_DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CAP)
        write_capacity(dir_rows[r].cap);
      else
        send_word(dir_rows[r].op, dir_rows[r].key, dir_rows[r].wdata,
                  dir_rows[r].fdata, dir_rows[r].typed, dir_rows[r].want);
    end

    // random phases; each waits for outstanding results, then writes a capacity
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cap = (ph == RANDOM_CAP_PHASE) ? CAP_W'($urandom_range(31)) : PHASE_CAPS[ph];
      write_capacity(cap);
      idle_on = (ph != QUIET_PHASE);
      pool_n = $urandom_range(2, POOL_MAX);
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
      repeat (WORDS_PER_PHASE) begin
        pick = $urandom_range(99);
        // mostly reuse a small key set so hits and LRU order matter
        if (pick < 85) key = key_pool[$urandom_range(pool_n - 1)];
        else if (pick < 95) key = $urandom;
        else key = pick[0] ? key_t'(0) : ONES32;
        if ($urandom_range(99) < 3) key_pool[$urandom_range(pool_n - 1)] = $urandom;
        send_word(op_t'($urandom_range(1)), key, {$urandom, $urandom},
                  {$urandom, $urandom}, 1'b0, NO_WANT);
      end
    end
    idle_on = 1'b1;

    // drain the outstanding results, then check that none are left
    @(negedge clk);
    start <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("accesses left without a result", 64'(pending_results.size()), 64'h0);

    $display("Checked %0d access words: %0d hits, %0d write-backs.",
             access_count, hit_count, writeback_count);
    $display("Capacity written %0d times, including 0, 1, 16 and 31.", cap_writes);
    if (error_count == 0) begin
      $display("lru_writeback_block_cache_tb passed");
    end else begin
      $display("lru_writeback_block_cache_tb failed");
    end
    $finish;
  end

endmodule
